@@ src/utf8sd_pkg.sv @@
// Shared widths and lead byte ranges for the UTF-8 stream decoder.
`default_nettype none
package utf8sd_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int PART_W = 15;
  localparam int LEFT_W = 2;

  localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
  localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD2_MAX  = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_MAX  = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_MAX  = 8'hF7;

  localparam logic [LEFT_W-1:0] LEFT_NONE  = 2'd0;
  localparam logic [LEFT_W-1:0] LEFT_ONE   = 2'd1;
  localparam logic [LEFT_W-1:0] LEFT_TWO   = 2'd2;
  localparam logic [LEFT_W-1:0] LEFT_THREE = 2'd3;

endpackage
`default_nettype wire

@@ src/utf8_stream_decoder_top.sv @@
// UTF-8 stream decoder: one byte per transfer in, one code point or error per transfer out.
//
// Input channel (in_valid/in_ready) carries one byte and a flag marking the
// last byte of a string. Output channel (out_valid/out_ready) carries a
// decoded code point, an error flag and the end-of-string flag.
// A byte that completes a sequence, a bad lead byte, or a string that ends
// mid-sequence produces one result; other bytes produce none. After an
// error, bytes are discarded up to and including the one marked last.
// The result is registered and shows on the output in the cycle after the
// transfer of the byte that causes it.
// Throughput: one byte per cycle while the output is read, set by the single
// output register; the decode state is updated in the same cycle the byte is taken.
// in_ready is high whenever the output register is empty or being read,
// so a stalled receiver holds the pending result and stops further input
// only while that result waits.
// Reset clears the sequence state, the discard flag and out_valid.
`default_nettype none
module utf8_stream_decoder_top
  import utf8sd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              last_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CP_W-1:0]        code_point,
  output logic                   error,
  output logic                   last_out
);

  logic [LEFT_W-1:0] bytes_left, bytes_left_next;
  logic [PART_W-1:0] partial_point, partial_point_next;
  logic              dropping, dropping_next;
  logic [LEFT_W-1:0] left_dec;
  logic              in_fire;
  logic              res_valid;
  logic [CP_W-1:0]   res_cp;
  logic              res_err;
  logic              res_last;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign left_dec = bytes_left - LEFT_ONE;

  always_comb begin
    bytes_left_next    = bytes_left;
    partial_point_next = partial_point;
    dropping_next      = dropping;
    res_valid          = 1'b0;
    res_cp             = '0;
    res_err            = 1'b0;
    res_last           = last_byte;
    if (dropping) begin
      if (last_byte) begin
        dropping_next = 1'b0;
      end
    end else if (bytes_left != LEFT_NONE) begin
      if (left_dec == LEFT_NONE) begin
        res_valid          = 1'b1;
        res_cp             = {partial_point, in_byte[5:0]};
        bytes_left_next    = LEFT_NONE;
        partial_point_next = '0;
      end else if (last_byte) begin
        res_valid          = 1'b1;
        res_err            = 1'b1;
        bytes_left_next    = LEFT_NONE;
        partial_point_next = '0;
      end else begin
        partial_point_next = {partial_point[PART_W-7:0], in_byte[5:0]};
        bytes_left_next    = left_dec;
      end
    end else begin
      case (in_byte) inside
        [8'h00:ASCII_MAX]: begin
          res_valid = 1'b1;
          res_cp    = {{(CP_W-BYTE_W){1'b0}}, in_byte};
        end
        [LEAD2_MIN:LEAD2_MAX]: begin
          partial_point_next = {{(PART_W-5){1'b0}}, in_byte[4:0]};
          bytes_left_next    = LEFT_ONE;
        end
        [LEAD3_MIN:LEAD3_MAX]: begin
          partial_point_next = {{(PART_W-4){1'b0}}, in_byte[3:0]};
          bytes_left_next    = LEFT_TWO;
        end
        [LEAD4_MIN:LEAD4_MAX]: begin
          partial_point_next = {{(PART_W-3){1'b0}}, in_byte[2:0]};
          bytes_left_next    = LEFT_THREE;
        end
        default: begin
          res_valid          = 1'b1;
          res_err            = 1'b1;
          partial_point_next = '0;
          dropping_next      = !last_byte;
        end
      endcase
      // multi-byte lead on the last byte: truncated
      if (bytes_left_next != LEFT_NONE && last_byte) begin
        res_valid          = 1'b1;
        res_err            = 1'b1;
        bytes_left_next    = LEFT_NONE;
        partial_point_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= LEFT_NONE;
      partial_point <= '0;
      dropping      <= 1'b0;
    end else if (in_fire) begin
      bytes_left    <= bytes_left_next;
      partial_point <= partial_point_next;
      dropping      <= dropping_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      code_point <= res_cp;
      error      <= res_err;
      last_out   <= res_last;
    end
  end

endmodule
`default_nettype wire

@@ src/utf8sd_checker.sv @@
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
`default_nettype none
module utf8sd_checker
  import utf8sd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CP_W-1:0]   code_point,
  input wire logic              error,
  input wire logic              last_out
);

  a_err_zero_cp: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> code_point == '0)
    else $error("error result with nonzero code point");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output register empty");

  a_new_result_from_transfer: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(error)
      && $stable(last_out))
    else $error("stalled result changed");

endmodule

bind utf8_stream_decoder_top utf8sd_checker u_utf8sd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .code_point (code_point),
  .error      (error),
  .last_out   (last_out)
);
`default_nettype wire
